// File: rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, constants and the verdict step table for the rhombus
// contour classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package rcc_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_BITS = 10;
    localparam int FRAME_BITS = 11;
    localparam int AREA_BITS  = 2 * COORD_BITS + 14;
    localparam int EDGE_W     = 2 * COORD_BITS;
    localparam int DIST_W     = 2 * FRAME_BITS + 1;
    localparam int VERT_W     = 2 * FRAME_BITS + 6;
    localparam int MAG_SQ_W   = 27;
    localparam int MUL_W      = 30;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int STEP_W     = 5;

    // last step of the verdict sequence
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(19);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FRAME_BITS-1:0] FRAME_RESET = FRAME_BITS'(700);

    // reject reason codes
    localparam logic [1:0] REASON_OK    = 2'd0;
    localparam logic [1:0] REASON_SHORT = 2'd1;
    localparam logic [1:0] REASON_VERT  = 2'd2;
    localparam logic [1:0] REASON_AREA  = 2'd3;

    // input and result items
    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last_point;
    } t_in_item;

    typedef struct packed {
        logic       is_rhombus;
        logic [1:0] reject_reason;
    } t_out_item;

    // contour point and tracker point
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_pix;

    typedef struct packed {
        logic [FRAME_BITS-1:0] x;
        logic [FRAME_BITS-1:0] y;
    } t_tpt;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE2,
        S_CLOSE1,
        S_CLOSE2,
        S_CLOSE3,
        S_VERD
    } t_state;

    // multiplier operand selection
    typedef enum logic [4:0] {
        MS_PRVX_INY,
        MS_PTX_PRVY,
        MS_PRVX_FY,
        MS_FX_PRVY,
        MS_ABX, MS_ABY,
        MS_CBX, MS_CBY,
        MS_DCX, MS_DCY,
        MS_DAX, MS_DAY,
        MS_ACX, MS_ACY,
        MS_BDX, MS_BDY,
        MS_DYB, MS_DYC,
        MS_SS,
        MS_DIAG,
        MS_S5,
        MS_DIAG6
    } t_msel;

    // what is done with the registered product
    typedef enum logic [3:0] {
        A_NONE,
        A_AREA_ADD,
        A_AREA_SUB,
        A_LOAD,
        A_SHORT,
        A_AC2,
        A_BD2,
        A_VERT_B,
        A_VERT_C,
        A_S2,
        A_CMP_LO,
        A_CMP_HI,
        A_FINISH
    } t_act;

    typedef struct packed {
        t_msel msel;
        t_act  act;
    } t_uop;

    typedef struct packed {
        t_state st;
        t_msel  msel;
        t_act   act;
        logic   mul_en;
    } t_ctrl;

    // verdict steps: all but the last issue a product; all but the first use the one before
    function automatic t_uop rcc_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        u.msel = MS_ABX;
        u.act  = A_NONE;
        case (step)
            5'd0:    begin u.msel = MS_ABX;   u.act = A_NONE;   end
            5'd1:    begin u.msel = MS_ABY;   u.act = A_LOAD;   end
            5'd2:    begin u.msel = MS_CBX;   u.act = A_SHORT;  end
            5'd3:    begin u.msel = MS_CBY;   u.act = A_LOAD;   end
            5'd4:    begin u.msel = MS_DCX;   u.act = A_SHORT;  end
            5'd5:    begin u.msel = MS_DCY;   u.act = A_LOAD;   end
            5'd6:    begin u.msel = MS_DAX;   u.act = A_SHORT;  end
            5'd7:    begin u.msel = MS_DAY;   u.act = A_LOAD;   end
            5'd8:    begin u.msel = MS_ACX;   u.act = A_SHORT;  end
            5'd9:    begin u.msel = MS_ACY;   u.act = A_LOAD;   end
            5'd10:   begin u.msel = MS_BDX;   u.act = A_AC2;    end
            5'd11:   begin u.msel = MS_BDY;   u.act = A_LOAD;   end
            5'd12:   begin u.msel = MS_DYB;   u.act = A_BD2;    end
            5'd13:   begin u.msel = MS_DYC;   u.act = A_VERT_B; end
            5'd14:   begin u.msel = MS_SS;    u.act = A_VERT_C; end
            5'd15:   begin u.msel = MS_DIAG;  u.act = A_S2;     end
            5'd16:   begin u.msel = MS_S5;    u.act = A_CMP_LO; end
            5'd17:   begin u.msel = MS_DIAG6; u.act = A_S2;     end
            5'd18:   begin u.msel = MS_ABX;   u.act = A_CMP_HI; end
            5'd19:   begin u.msel = MS_ABX;   u.act = A_FINISH; end
            default: begin u.msel = MS_ABX;   u.act = A_NONE;   end
        endcase
        return u;
    endfunction

    // magnitude of the difference of two tracker coordinates
    function automatic logic [FRAME_BITS-1:0] abs_diff(
        input logic [FRAME_BITS-1:0] u,
        input logic [FRAME_BITS-1:0] v
    );
        return (u >= v) ? (u - v) : (v - u);
    endfunction

endpackage

`default_nettype wire

// File: rtl/rcc_mul.sv
// ----------------------------------------------------------------------------
// rcc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_mul (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [rcc_pkg::MUL_W-1:0]  i_a,
    input  wire logic [rcc_pkg::MUL_W-1:0]  i_b,
    output logic      [rcc_pkg::PROD_W-1:0] o_prod
);

    logic [rcc_pkg::PROD_W-1:0] r_prod;

    // product register, held while idle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{rcc_pkg::MUL_W{1'b0}}, i_a} * {{rcc_pkg::MUL_W{1'b0}}, i_b};
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: rtl/rcc_seq.sv
// ----------------------------------------------------------------------------
// rcc_seq
// Sequencer: shoelace edge steps per point, closing edge and the verdict
// steps that drive the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rcc_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic           i_last,
    input  wire logic           i_started,
    input  wire logic           i_out_free,
    output rcc_pkg::t_ctrl      o_ctrl
);

    rcc_pkg::t_state            r_state, n_state;
    logic [rcc_pkg::STEP_W-1:0] r_step, n_step;
    logic                       r_sub_pend, n_sub_pend;
    logic                       r_last, n_last;
    rcc_pkg::t_uop              uop;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rcc_pkg::S_IDLE;
            r_step     <= '0;
            r_sub_pend <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_sub_pend <= n_sub_pend;
            r_last     <= n_last;
        end
    end

    assign uop = rcc_pkg::rcc_uop(r_step);

    // next state and control
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_sub_pend  = r_sub_pend;
        n_last      = r_last;
        o_ctrl.st     = r_state;
        o_ctrl.msel   = rcc_pkg::MS_PRVX_INY;
        o_ctrl.act    = rcc_pkg::A_NONE;
        o_ctrl.mul_en = 1'b0;
        case (r_state)
            rcc_pkg::S_IDLE: begin
                // first edge product straight from the incoming item
                o_ctrl.mul_en = i_accept && i_started;
                if (r_sub_pend) begin
                    o_ctrl.act = rcc_pkg::A_AREA_SUB;
                    n_sub_pend = 1'b0;
                end
                if (i_accept) begin
                    n_last = i_last;
                    if (i_started) begin
                        n_state = rcc_pkg::S_EDGE2;
                    end else if (i_last) begin
                        n_state = rcc_pkg::S_CLOSE1;
                    end
                end
            end
            rcc_pkg::S_EDGE2: begin
                o_ctrl.msel   = rcc_pkg::MS_PTX_PRVY;
                o_ctrl.mul_en = 1'b1;
                o_ctrl.act    = rcc_pkg::A_AREA_ADD;
                n_sub_pend    = 1'b1;
                n_state       = r_last ? rcc_pkg::S_CLOSE1 : rcc_pkg::S_IDLE;
            end
            rcc_pkg::S_CLOSE1: begin
                o_ctrl.msel   = rcc_pkg::MS_PRVX_FY;
                o_ctrl.mul_en = 1'b1;
                if (r_sub_pend) begin
                    o_ctrl.act = rcc_pkg::A_AREA_SUB;
                    n_sub_pend = 1'b0;
                end
                n_state = rcc_pkg::S_CLOSE2;
            end
            rcc_pkg::S_CLOSE2: begin
                o_ctrl.msel   = rcc_pkg::MS_FX_PRVY;
                o_ctrl.mul_en = 1'b1;
                o_ctrl.act    = rcc_pkg::A_AREA_ADD;
                n_state       = rcc_pkg::S_CLOSE3;
            end
            rcc_pkg::S_CLOSE3: begin
                o_ctrl.act = rcc_pkg::A_AREA_SUB;
                n_step     = '0;
                n_state    = rcc_pkg::S_VERD;
            end
            rcc_pkg::S_VERD: begin
                o_ctrl.msel = uop.msel;
                o_ctrl.act  = uop.act;
                if (r_step == rcc_pkg::LAST_STEP) begin
                    // wait here until the result register is free
                    if (i_out_free) begin
                        n_state = rcc_pkg::S_IDLE;
                    end else begin
                        o_ctrl.act = rcc_pkg::A_NONE;
                    end
                end else begin
                    o_ctrl.mul_en = 1'b1;
                    n_step        = r_step + 1'b1;
                end
            end
            default: begin
                n_state = rcc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rhombus_contour_classifier_top.sv
// ----------------------------------------------------------------------------
// rhombus_contour_classifier_top
// Tracks the extreme points and shoelace area of a contour and gives one
// rhombus verdict on its last point.
// ----------------------------------------------------------------------------
//  channel | signals                               | item
//  --------+---------------------------------------+---------------------------
//  in      | i_in_valid, o_in_stall, i_in_item     | one contour point
//  out     | o_out_valid, i_out_stall, o_out_item  | verdict on the last point
//  cfg     | i_cfg_wr_en, i_cfg_index, i_cfg_data  | frame width / height
//
//  A point after the first of its contour takes two shoelace products on the
//  one shared multiplier; the first point takes none.
//  A last point runs its edge, the closing edge and 20 verdict steps, all
//  on the same multiplier.
//  Reset is synchronous and clears the control state; no clearing pass.
//  The verdict waits in its last step while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module rhombus_contour_classifier_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire rcc_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output rcc_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [rcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [rcc_pkg::FRAME_BITS-1:0] i_cfg_data
);

    localparam int FB = rcc_pkg::FRAME_BITS;
    localparam int MW = rcc_pkg::MUL_W;
    localparam int DW = rcc_pkg::DIST_W;
    localparam int AW = rcc_pkg::AREA_BITS;
    localparam int SW = rcc_pkg::MAG_SQ_W;
    localparam int VW = rcc_pkg::VERT_W;

    rcc_pkg::t_ctrl ctrl;

    logic [FB-1:0] r_frame_w, r_frame_h;
    logic          r_started;
    rcc_pkg::t_pix r_pt, r_first, r_prev, in_pt;
    rcc_pkg::t_tpt r_left, r_right, r_top, r_bottom;
    rcc_pkg::t_tpt base_left, base_right, base_top, base_bottom;
    logic [AW-1:0] r_area, n_area;
    logic [AW-1:0] r_mag;
    logic [MW-1:0] r_s5;
    logic [DW-1:0] r_acc, r_ac2, r_bd2;
    logic [MW-1:0] r_ac6, r_bd6;
    logic [rcc_pkg::PROD_W-1:0] r_s2, prod;
    logic          r_short, r_vert, r_f3;
    logic          r_out_valid;
    rcc_pkg::t_out_item r_out;
    logic [1:0]    reason;
    logic          accept, out_free, big;
    logic [MW-1:0] mul_a, mul_b;
    logic [FB-1:0] sq_op;
    logic [DW-1:0] dist_sum;
    logic [VW-1:0] vert_lim;

    assign in_pt.x    = i_in_item.point_x;
    assign in_pt.y    = i_in_item.point_y;
    assign o_in_stall = (ctrl.st != rcc_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // sequencer and shared multiplier
    rcc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_last     (i_in_item.last_point),
        .i_started  (r_started),
        .i_out_free (out_free),
        .o_ctrl     (ctrl)
    );

    rcc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= rcc_pkg::FRAME_RESET;
            r_frame_h <= rcc_pkg::FRAME_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == rcc_pkg::CFG_FRAME_WIDTH) begin
                r_frame_w <= i_cfg_data;
            end else if (i_cfg_index == rcc_pkg::CFG_FRAME_HEIGHT) begin
                r_frame_h <= i_cfg_data;
            end
        end
    end

    // tracker start values on the first point of a contour
    always_comb begin
        base_left   = r_left;
        base_top    = r_top;
        base_right  = r_right;
        base_bottom = r_bottom;
        if (!r_started) begin
            base_left.x   = r_frame_w;
            base_left.y   = r_frame_h;
            base_top      = base_left;
            base_right    = '0;
            base_bottom   = '0;
        end
    end

    // point registers and extreme point trackers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pt <= in_pt;
            r_left   <= ({1'b0, in_pt.x} < base_left.x) ?
                        {1'b0, in_pt.x, 1'b0, in_pt.y} : base_left;
            r_right  <= ({1'b0, in_pt.x} > base_right.x) ?
                        {1'b0, in_pt.x, 1'b0, in_pt.y} : base_right;
            r_top    <= ({1'b0, in_pt.y} < base_top.y) ?
                        {1'b0, in_pt.x, 1'b0, in_pt.y} : base_top;
            r_bottom <= ({1'b0, in_pt.y} > base_bottom.y) ?
                        {1'b0, in_pt.x, 1'b0, in_pt.y} : base_bottom;
            if (!r_started) begin
                r_first <= in_pt;
                r_prev  <= in_pt;
            end
        end else if (ctrl.st == rcc_pkg::S_EDGE2) begin
            r_prev <= r_pt;
        end
    end

    // contour started flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (accept) begin
            r_started <= 1'b1;
        end else if (ctrl.act == rcc_pkg::A_FINISH) begin
            r_started <= 1'b0;
        end
    end

    // shoelace accumulator, modulo 2^AREA_BITS
    always_comb begin
        n_area = r_area;
        case (ctrl.act)
            rcc_pkg::A_AREA_ADD:
                n_area = r_area + AW'(prod[rcc_pkg::EDGE_W-1:0]);
            rcc_pkg::A_AREA_SUB:
                n_area = r_area - AW'(prod[rcc_pkg::EDGE_W-1:0]);
            default: n_area = r_area;
        endcase
        if (accept && !r_started) begin
            n_area = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= n_area;
    end

    // derived values, stable well before the steps that use them
    always_ff @(posedge i_clk) begin
        r_mag <= r_area[AW-1] ? (~r_area + 1'b1) : r_area;
        r_s5  <= MW'({r_mag[SW-1:0], 2'b00}) + MW'(r_mag[SW-1:0]);
        r_ac6 <= MW'({r_ac2, 2'b00}) + MW'({r_ac2, 1'b0});
        r_bd6 <= MW'({r_bd2, 2'b00}) + MW'({r_bd2, 1'b0});
    end

    assign big = (r_mag[AW-1:SW] != '0);

    // square operand: a = top, b = left, c = bottom, d = right
    always_comb begin
        case (ctrl.msel)
            rcc_pkg::MS_ABX: sq_op = rcc_pkg::abs_diff(r_top.x, r_left.x);
            rcc_pkg::MS_ABY: sq_op = rcc_pkg::abs_diff(r_top.y, r_left.y);
            rcc_pkg::MS_CBX: sq_op = rcc_pkg::abs_diff(r_bottom.x, r_left.x);
            rcc_pkg::MS_CBY: sq_op = rcc_pkg::abs_diff(r_bottom.y, r_left.y);
            rcc_pkg::MS_DCX: sq_op = rcc_pkg::abs_diff(r_right.x, r_bottom.x);
            rcc_pkg::MS_DCY: sq_op = rcc_pkg::abs_diff(r_right.y, r_bottom.y);
            rcc_pkg::MS_DAX: sq_op = rcc_pkg::abs_diff(r_right.x, r_top.x);
            rcc_pkg::MS_DAY: sq_op = rcc_pkg::abs_diff(r_right.y, r_top.y);
            rcc_pkg::MS_ACX: sq_op = rcc_pkg::abs_diff(r_bottom.x, r_top.x);
            rcc_pkg::MS_ACY: sq_op = rcc_pkg::abs_diff(r_bottom.y, r_top.y);
            rcc_pkg::MS_BDX: sq_op = rcc_pkg::abs_diff(r_left.x, r_right.x);
            rcc_pkg::MS_BDY: sq_op = rcc_pkg::abs_diff(r_left.y, r_right.y);
            rcc_pkg::MS_DYB: sq_op = rcc_pkg::abs_diff(r_left.y, r_top.y);
            rcc_pkg::MS_DYC: sq_op = rcc_pkg::abs_diff(r_bottom.y, r_top.y);
            default:         sq_op = '0;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = MW'(sq_op);
        mul_b = MW'(sq_op);
        case (ctrl.msel)
            rcc_pkg::MS_PRVX_INY: begin
                mul_a = MW'(r_prev.x);
                mul_b = MW'(in_pt.y);
            end
            rcc_pkg::MS_PTX_PRVY: begin
                mul_a = MW'(r_pt.x);
                mul_b = MW'(r_prev.y);
            end
            rcc_pkg::MS_PRVX_FY: begin
                mul_a = MW'(r_prev.x);
                mul_b = MW'(r_first.y);
            end
            rcc_pkg::MS_FX_PRVY: begin
                mul_a = MW'(r_first.x);
                mul_b = MW'(r_prev.y);
            end
            rcc_pkg::MS_SS: begin
                mul_a = MW'(r_mag[SW-1:0]);
                mul_b = MW'(r_mag[SW-1:0]);
            end
            rcc_pkg::MS_DIAG: begin
                mul_a = MW'(r_ac2);
                mul_b = MW'(r_bd2);
            end
            rcc_pkg::MS_S5: begin
                mul_a = r_s5;
                mul_b = r_s5;
            end
            rcc_pkg::MS_DIAG6: begin
                mul_a = r_ac6;
                mul_b = r_bd6;
            end
            default: begin
                mul_a = MW'(sq_op);
                mul_b = MW'(sq_op);
            end
        endcase
    end

    // distance sum and vertical limit from the registered product
    assign dist_sum = r_acc + prod[DW-1:0];
    assign vert_lim = {prod[2*FB-1:0], 6'b000000};

    // verdict flags and stored results
    always_ff @(posedge i_clk) begin
        if (ctrl.st == rcc_pkg::S_CLOSE3) begin
            r_short <= 1'b0;
            r_vert  <= 1'b0;
            r_f3    <= 1'b0;
        end
        case (ctrl.act)
            rcc_pkg::A_LOAD:   r_acc <= prod[DW-1:0];
            rcc_pkg::A_SHORT:  r_short <= r_short || (dist_sum <= DW'(1));
            rcc_pkg::A_AC2:    r_ac2 <= dist_sum;
            rcc_pkg::A_BD2:    r_bd2 <= dist_sum;
            rcc_pkg::A_VERT_B: r_vert <= r_vert || (r_left.y <= r_top.y) ||
                                         (VW'(r_ac2) >= vert_lim);
            rcc_pkg::A_VERT_C: r_vert <= r_vert || (r_bottom.y <= r_top.y) ||
                                         (VW'(r_ac2) >= vert_lim);
            rcc_pkg::A_S2:     r_s2 <= prod;
            rcc_pkg::A_CMP_LO: r_f3 <= r_f3 || (r_s2 < prod);
            rcc_pkg::A_CMP_HI: r_f3 <= r_f3 || (r_s2 > prod);
            default: ;
        endcase
    end

    // reason priority
    always_comb begin
        if (r_short) begin
            reason = rcc_pkg::REASON_SHORT;
        end else if (r_vert) begin
            reason = rcc_pkg::REASON_VERT;
        end else if (r_f3 || big || (r_ac2 == '0) || (r_bd2 == '0)) begin
            reason = rcc_pkg::REASON_AREA;
        end else begin
            reason = rcc_pkg::REASON_OK;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.act == rcc_pkg::A_FINISH) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.act == rcc_pkg::A_FINISH) begin
            r_out.is_rhombus    <= (reason == rcc_pkg::REASON_OK);
            r_out.reject_reason <= reason;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// File: sim/rhombus_contour_classifier_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhombus_contour_classifier_top_tb
// Drives contour points into the classifier and checks each verdict. A
// scoreboard class follows the extreme points and the shoelace sum and
// predicts the verdict on every last point. Stimulus runs in phases:
// - a short directed set of corner cases
// - random rhombi, skewed and tiny shapes, and random noise, under several
//   frame settings and idle patterns
// ----------------------------------------------------------------------------

module rhombus_contour_classifier_top_tb;

    localparam int COORD_W        = rcc_pkg::COORD_BITS;
    localparam int AREA_W         = rcc_pkg::AREA_BITS;
    localparam int FRAME_W        = rcc_pkg::FRAME_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_HOLD  = 400;
    localparam int SETTLE_CYCLES  = 30;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;

    typedef struct {
        int x;
        int y;
    } t_corner;

    typedef enum {
        SHAPE_PLAIN,
        SHAPE_SKEW,
        SHAPE_TINY
    } t_shape;

    // verdict prediction and checking
    class t_verdict_board;
        int unsigned             errors;
        int unsigned             verdicts_checked;
        int                      frame_w;
        int                      frame_h;
        t_corner                 left_pt;
        t_corner                 right_pt;
        t_corner                 top_pt;
        t_corner                 bottom_pt;
        t_corner                 first_pt;
        t_corner                 prev_pt;
        bit                      started;
        logic [AREA_W-1:0]       area;
        rcc_pkg::t_out_item      verdicts_due[$];

        function new();
            errors           = 0;
            verdicts_checked = 0;
            frame_w          = int'(rcc_pkg::FRAME_RESET);
            frame_h          = int'(rcc_pkg::FRAME_RESET);
            started          = 1'b0;
            area             = '0;
        endfunction

        function void write_frame(logic [rcc_pkg::CFG_IDX_W-1:0] idx, int value);
            if (idx == rcc_pkg::CFG_FRAME_WIDTH) begin
                frame_w = value & ((1 << FRAME_W) - 1);
            end else begin
                frame_h = value & ((1 << FRAME_W) - 1);
            end
        endfunction

        function void add_shoelace_term(t_corner a, t_corner b);
            area = area + AREA_W'(a.x * b.y) - AREA_W'(b.x * a.y);
        endfunction

        function logic [63:0] dist_sq(t_corner a, t_corner b);
            int dx;
            int dy;
            dx = a.x - b.x;
            dy = a.y - b.y;
            return 64'(dx * dx + dy * dy);
        endfunction

        // side corner not clearly below the top corner
        function bit too_shallow(int top_y, int side_y, logic [63:0] ac_sq);
            int dy;
            dy = side_y - top_y;
            if (dy <= 0) begin
                return 1'b1;
            end
            return ac_sq >= 64'(64 * dy * dy);
        endfunction

        function logic [1:0] judge_contour();
            logic [63:0]          ac_sq;
            logic [63:0]          bd_sq;
            logic [AREA_W-1:0]    mag;
            logic [127:0]         area_sq;
            logic [127:0]         diag_sq;
            if (dist_sq(top_pt, left_pt) <= 1 || dist_sq(bottom_pt, left_pt) <= 1 ||
                dist_sq(right_pt, bottom_pt) <= 1 || dist_sq(right_pt, top_pt) <= 1) begin
                return rcc_pkg::REASON_SHORT;
            end
            ac_sq = dist_sq(bottom_pt, top_pt);
            bd_sq = dist_sq(left_pt, right_pt);
            if (too_shallow(top_pt.y, left_pt.y, ac_sq) ||
                too_shallow(top_pt.y, bottom_pt.y, ac_sq)) begin
                return rcc_pkg::REASON_VERT;
            end
            if (ac_sq == 0 || bd_sq == 0) begin
                return rcc_pkg::REASON_AREA;
            end
            // magnitude of the two's complement area sum
            mag = area;
            if (mag[AREA_W-1]) begin
                mag = -mag;
            end
            area_sq = 128'(mag) * 128'(mag);
            diag_sq = 128'(ac_sq) * 128'(bd_sq);
            if (area_sq < diag_sq) begin
                return rcc_pkg::REASON_AREA;
            end
            if (25 * area_sq > 36 * diag_sq) begin
                return rcc_pkg::REASON_AREA;
            end
            return rcc_pkg::REASON_OK;
        endfunction

        function void take_point(rcc_pkg::t_in_item it);
            t_corner            p;
            rcc_pkg::t_out_item v;
            p.x = int'(it.point_x);
            p.y = int'(it.point_y);
            // first point loads the trackers from the current frame
            if (!started) begin
                left_pt.x   = frame_w;
                left_pt.y   = frame_h;
                top_pt      = left_pt;
                right_pt.x  = 0;
                right_pt.y  = 0;
                bottom_pt   = right_pt;
                first_pt    = p;
                prev_pt     = p;
                area        = '0;
                started     = 1'b1;
            end else begin
                add_shoelace_term(prev_pt, p);
                prev_pt = p;
            end
            // ties keep the earlier point
            if (p.x > right_pt.x) begin
                right_pt = p;
            end
            if (p.x < left_pt.x) begin
                left_pt = p;
            end
            if (p.y > bottom_pt.y) begin
                bottom_pt = p;
            end
            if (p.y < top_pt.y) begin
                top_pt = p;
            end
            if (!it.last_point) begin
                return;
            end
            add_shoelace_term(prev_pt, first_pt);
            v.reject_reason = judge_contour();
            v.is_rhombus    = (v.reject_reason == rcc_pkg::REASON_OK);
            verdicts_due.push_back(v);
            started = 1'b0;
        endfunction

        task report(string msg);
            if (errors < 100) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_verdict(rcc_pkg::t_out_item got);
            rcc_pkg::t_out_item want;
            if (verdicts_due.size() == 0) begin
                report($sformatf("verdict with none pending: rhombus=%0b reason=%0d",
                                 got.is_rhombus, got.reject_reason));
                return;
            end
            want = verdicts_due.pop_front();
            if (got.is_rhombus !== want.is_rhombus) begin
                report($sformatf("verdict %0d is_rhombus got %0b want %0b",
                                 verdicts_checked, got.is_rhombus, want.is_rhombus));
            end
            if (got.reject_reason !== want.reject_reason) begin
                report($sformatf("verdict %0d reject_reason got %0d want %0d",
                                 verdicts_checked, got.reject_reason, want.reject_reason));
            end
            verdicts_checked++;
        endtask
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    rcc_pkg::t_in_item                 i_in_item = '0;
    logic                              o_out_valid;
    logic                              i_out_stall;
    rcc_pkg::t_out_item                o_out_item;
    logic                              i_cfg_wr_en = 1'b0;
    logic [rcc_pkg::CFG_IDX_W-1:0]     i_cfg_index = rcc_pkg::CFG_FRAME_WIDTH;
    logic [FRAME_W-1:0]                i_cfg_data = '0;

    t_verdict_board    board = new();
    rcc_pkg::t_in_item contour_q[$];
    int                send_idle_max = 10;
    int                recv_idle_max = 10;

    rhombus_contour_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #10 i_clk = ~i_clk;

    // contour building
    function automatic void add_pt(int x, int y);
        rcc_pkg::t_in_item it;
        it.point_x    = COORD_W'((x < 0) ? 0 : ((x > COORD_MAX) ? COORD_MAX : x));
        it.point_y    = COORD_W'((y < 0) ? 0 : ((y > COORD_MAX) ? COORD_MAX : y));
        it.last_point = 1'b0;
        contour_q.push_back(it);
    endfunction

    function automatic void close_contour();
        rcc_pkg::t_in_item it;
        it = contour_q.pop_back();
        it.last_point = 1'b1;
        contour_q.push_back(it);
    endfunction

    // rhombus traced from a random corner, either way round, with optional
    // edge points bent in or out and jittered corners
    function automatic void add_rhombus(t_shape shape);
        int h, v, cx, cy, steps, bend, first, dir, i, j, a, b, px, py;
        int vx[4];
        int vy[4];
        if (shape == SHAPE_TINY) begin
            h = $urandom_range(0, 1);
            v = $urandom_range(0, 2);
        end else if ($urandom_range(0, 9) == 0) begin
            h = $urandom_range(2, 511);
            v = $urandom_range(2, 511);
        end else begin
            h = $urandom_range(2, 40);
            v = $urandom_range(2, 40);
        end
        cx = $urandom_range(h, COORD_MAX - h);
        cy = $urandom_range(v, COORD_MAX - v);
        vx = '{cx, cx + h, cx, cx - h};
        vy = '{cy - v, cy, cy + v, cy};
        if ($urandom_range(0, 3) == 0) begin
            for (i = 0; i < 4; i++) begin
                vx[i] += $urandom_range(0, 2) - 1;
                vy[i] += $urandom_range(0, 2) - 1;
            end
        end
        // left corner pulled up toward the top corner
        if (shape == SHAPE_SKEW) begin
            vy[3] = cy - v + $urandom_range(0, v);
        end
        steps = $urandom_range(0, 3);
        bend  = $urandom_range(0, 2) - 1;
        first = $urandom_range(0, 3);
        dir   = $urandom_range(0, 1);
        for (i = 0; i < 4; i++) begin
            a = dir ? (first + 4 - i) % 4 : (first + i) % 4;
            b = dir ? (a + 3) % 4 : (a + 1) % 4;
            add_pt(vx[a], vy[a]);
            for (j = 1; j <= steps; j++) begin
                px = vx[a] + (vx[b] - vx[a]) * j / (steps + 1);
                py = vy[a] + (vy[b] - vy[a]) * j / (steps + 1);
                if (px > cx) begin
                    px += bend;
                end else if (px < cx) begin
                    px -= bend;
                end
                if (py > cy) begin
                    py += bend;
                end else if (py < cy) begin
                    py -= bend;
                end
                add_pt(px, py);
            end
        end
        close_contour();
    endfunction

    function automatic void add_noise();
        int n, i;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            add_pt($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        end
        close_contour();
    endfunction

    function automatic void build_random(int count);
        int pick;
        while (contour_q.size() < count) begin
            pick = $urandom_range(0, 19);
            if (pick <= 10) begin
                add_rhombus(SHAPE_PLAIN);
            end else if (pick <= 13) begin
                add_rhombus(SHAPE_SKEW);
            end else if (pick <= 16) begin
                add_rhombus(SHAPE_TINY);
            end else begin
                add_noise();
            end
        end
    endfunction

    // corner cases at the reset frame
    function automatic void build_directed();
        // single point contours at both ends of the range
        add_pt(0, 0);
        close_contour();
        add_pt(COORD_MAX, COORD_MAX);
        close_contour();
        // full frame square, top and left corners coincide
        add_pt(0, 0);
        add_pt(COORD_MAX, 0);
        add_pt(COORD_MAX, COORD_MAX);
        add_pt(0, COORD_MAX);
        close_contour();
        // largest exact rhombus
        add_pt(511, 0);
        add_pt(1022, 511);
        add_pt(511, 1022);
        add_pt(0, 511);
        close_contour();
        // vertical line, zero horizontal diagonal
        add_pt(5, 50);
        add_pt(5, 10);
        add_pt(5, 90);
        close_contour();
        // left corner one row below the top
        add_pt(100, 100);
        add_pt(150, 150);
        add_pt(100, 200);
        add_pt(50, 101);
        close_contour();
        // all points past the frame start, left and top trackers keep their start values
        add_pt(800, 900);
        add_pt(900, 800);
        add_pt(1000, 900);
        add_pt(900, 1000);
        close_contour();
    endfunction

    // one point onto the input channel
    task automatic send_point(rcc_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.take_point(it);
    endtask

    task automatic run_points();
        foreach (contour_q[k]) begin
            send_point(contour_q[k]);
        end
        contour_q.delete();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // wait for all verdicts, then let the block finish any work in flight
    task automatic settle();
        while (board.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= rcc_pkg::CFG_FRAME_WIDTH;
        i_cfg_data  <= FRAME_W'(w);
        board.write_frame(rcc_pkg::CFG_FRAME_WIDTH, w);
        @(negedge i_clk);
        i_cfg_index <= rcc_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data  <= FRAME_W'(h);
        board.write_frame(rcc_pkg::CFG_FRAME_HEIGHT, h);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // verdict receiver with random holds and one long hold to back up the block
    initial begin : verdict_sink
        int hold;
        int seen;
        hold = 0;
        seen = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                board.check_verdict(o_out_item);
                seen++;
                hold = (seen == 30) ? PRESSURE_HOLD : $urandom_range(0, recv_idle_max);
            end
        end
    end

    // ends the run when no item moves on either channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    // test sequence
    initial begin : run_test
        int ph;
        int w;
        int h;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        build_directed();
        run_points();

        for (ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0: begin w = 1;    h = 1;    send_idle_max = 10; recv_idle_max = 10; end
                1: begin w = 1024; h = 1024; send_idle_max = 0;  recv_idle_max = 0;  end
                2: begin w = 1023; h = 1024; send_idle_max = 10; recv_idle_max = 0;  end
                3: begin w = 1;    h = 1023; send_idle_max = 0;  recv_idle_max = 10; end
                4: begin
                    w = $urandom_range(1, 1024);
                    h = $urandom_range(1, 1024);
                    send_idle_max = 10;
                    recv_idle_max = 10;
                end
                default: begin w = 700; h = 700; send_idle_max = 3; recv_idle_max = 10; end
            endcase
            set_frame(w, h);
            build_random(250);
            run_points();
        end

        settle();
        if (board.verdicts_due.size() != 0) begin
            board.report($sformatf("%0d verdicts never arrived", board.verdicts_due.size()));
        end
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rcc_pkg.sv
rtl/rcc_mul.sv
rtl/rcc_seq.sv
rtl/rhombus_contour_classifier_top.sv
sim/rhombus_contour_classifier_top_tb.sv
